// File: hw/rtl/ftd_pkg.sv
package ftd_pkg;

	localparam logic RECORD_FILE = 1'b0;
	localparam logic RECORD_TAG  = 1'b1;

	localparam logic [7:0] TAG_AUDIO = 8'd8;
	localparam logic [7:0] TAG_VIDEO = 8'd9;

	// byte positions within each section
	localparam logic [3:0] POS_VERSION   = 4'd3;
	localparam logic [3:0] POS_FLAGS     = 4'd4;
	localparam logic [3:0] POS_HSIZE_0   = 4'd5;
	localparam logic [3:0] POS_HDR_LAST  = 4'd8;
	localparam logic [3:0] POS_PREV_LAST = 4'd3;
	localparam logic [3:0] POS_TYPE      = 4'd0;
	localparam logic [3:0] POS_SIZE_LAST = 4'd3;
	localparam logic [3:0] POS_TIME_LAST = 4'd6;
	localparam logic [3:0] POS_TIME_EXT  = 4'd7;
	localparam logic [3:0] POS_TAG_LAST  = 4'd10;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  format_version;
		logic [7:0]  header_flags;
		logic [31:0] header_size;
		logic [7:0]  tag_kind;
		logic [23:0] payload_size;
		logic [31:0] time_stamp;
		logic [23:0] stream_number;
		logic [31:0] tag_count;
		logic [31:0] frame_number;
	} result_t;

endpackage

// File: hw/rtl/ftd_in_stage.sv
module ftd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       blocked,
	output logic       advance,
	output logic [7:0] byte_s1
);

	logic valid_s1;

	assign in_stall = valid_s1 & blocked;
	assign advance  = valid_s1 & ~blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

// File: hw/rtl/ftd_parse.sv
module ftd_parse #(
	parameter int COUNTER_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       byte_s1,
	output logic             res_valid,
	output ftd_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_FILE,
		PH_PREV,
		PH_TAG,
		PH_PAY
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [3:0]              pos_q, pos_d;
	logic [23:0]             left_q, left_d;
	logic [7:0]              type_q, type_d;
	logic [31:0]             size_q, size_d;
	logic [31:0]             time_q, time_d;
	logic [23:0]             stream_q, stream_d;
	logic [7:0]              version_q, version_d;
	logic [7:0]              flags_q, flags_d;
	logic [COUNTER_BITS-1:0] tags_q, tags_d;
	logic [COUNTER_BITS-1:0] audio_q, audio_d;
	logic [COUNTER_BITS-1:0] video_q, video_d;
	logic [COUNTER_BITS-1:0] frame;
	logic [COUNTER_BITS+31:0] tags_ext, frame_ext;

	// counters may be narrower or wider than the 32-bit report
	assign tags_ext  = {32'b0, tags_d};
	assign frame_ext = {32'b0, frame};

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		left_d    = left_q;
		type_d    = type_q;
		size_d    = size_q;
		time_d    = time_q;
		stream_d  = stream_q;
		version_d = version_q;
		flags_d   = flags_q;
		tags_d    = tags_q;
		audio_d   = audio_q;
		video_d   = video_q;
		frame     = '0;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_FILE: begin
				if (pos_q == ftd_pkg::POS_VERSION) begin
					version_d = byte_s1;
				end else if (pos_q == ftd_pkg::POS_FLAGS) begin
					flags_d = byte_s1;
				end else if (pos_q >= ftd_pkg::POS_HSIZE_0) begin
					size_d = {size_q[23:0], byte_s1};
				end
				if (pos_q >= ftd_pkg::POS_HDR_LAST) begin
					res_valid          = 1'b1;
					res.record_kind    = ftd_pkg::RECORD_FILE;
					res.format_version = version_d;
					res.header_flags   = flags_d;
					res.header_size    = size_d;
					phase_d            = PH_PREV;
					pos_d              = '0;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_PREV: begin
				if (pos_q >= ftd_pkg::POS_PREV_LAST) begin
					phase_d = PH_TAG;
					pos_d   = '0;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_TAG: begin
				if (pos_q == ftd_pkg::POS_TYPE) begin
					type_d = byte_s1;
				end else if (pos_q <= ftd_pkg::POS_SIZE_LAST) begin
					size_d = {8'h00, size_q[15:0], byte_s1};
				end else if (pos_q <= ftd_pkg::POS_TIME_LAST) begin
					time_d = {8'h00, time_q[15:0], byte_s1};
				end else if (pos_q == ftd_pkg::POS_TIME_EXT) begin
					time_d = {byte_s1, time_q[23:0]};
				end else begin
					stream_d = {stream_q[15:0], byte_s1};
				end
				if (pos_q >= ftd_pkg::POS_TAG_LAST) begin
					tags_d = tags_q + 1'b1;
					if (type_q == ftd_pkg::TAG_AUDIO) begin
						frame   = audio_q;
						audio_d = audio_q + 1'b1;
					end else if (type_q == ftd_pkg::TAG_VIDEO) begin
						frame   = video_q;
						video_d = video_q + 1'b1;
					end
					res_valid         = 1'b1;
					res.record_kind   = ftd_pkg::RECORD_TAG;
					res.tag_kind      = type_d;
					res.payload_size  = size_d[23:0];
					res.time_stamp    = time_d;
					res.stream_number = stream_d;
					res.tag_count     = tags_ext[31:0];
					res.frame_number  = frame_ext[31:0];
					pos_d             = '0;
					left_d            = size_d[23:0];
					phase_d           = (size_d[23:0] == 24'd0) ? PH_PREV : PH_PAY;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_PAY: begin
				if (left_q != 24'd0) begin
					left_d = left_q - 24'd1;
				end
				if (left_q <= 24'd1) begin
					phase_d = PH_PREV;
					pos_d   = '0;
				end
			end
			default: begin
				phase_d = PH_FILE;
				pos_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FILE;
			pos_q     <= '0;
			left_q    <= '0;
			type_q    <= '0;
			size_q    <= '0;
			time_q    <= '0;
			stream_q  <= '0;
			version_q <= '0;
			flags_q   <= '0;
			tags_q    <= '0;
			audio_q   <= '0;
			video_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			left_q    <= left_d;
			type_q    <= type_d;
			size_q    <= size_d;
			time_q    <= time_d;
			stream_q  <= stream_d;
			version_q <= version_d;
			flags_q   <= flags_d;
			tags_q    <= tags_d;
			audio_q   <= audio_d;
			video_q   <= video_d;
		end
	end

endmodule

// File: hw/rtl/ftd_out_stage.sv
module ftd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_load,
	input  ftd_pkg::result_t res,
	output logic             blocked,
	output logic             out_valid,
	input  logic             out_stall,
	output ftd_pkg::result_t res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign blocked   = valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!blocked) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load && !blocked) begin
			res_q <= res;
		end
	end

endmodule

// File: hw/rtl/flv_tag_header_deframer.sv
// FLV tag header deframer. Takes one byte of an FLV file per transaction and
// may take a byte in every cycle. It emits one record when the 9-byte file
// header completes and one when each 11-byte tag header completes; previous
// tag sizes and payload bytes are consumed without output. A record passes
// through the input byte register and the result register before it is
// presented at the outputs. The rate is set by the next-state logic between
// the input byte register and the result register; it only drops while a
// finished record is held by out_stall, which then backs up into in_stall.
module flv_tag_header_deframer #(
	parameter int COUNTER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_kind,
	output logic [7:0]  format_version,
	output logic [7:0]  header_flags,
	output logic [31:0] header_size,
	output logic [7:0]  tag_kind,
	output logic [23:0] payload_size,
	output logic [31:0] time_stamp,
	output logic [23:0] stream_number,
	output logic [31:0] tag_count,
	output logic [31:0] frame_number
);

	logic             blocked;
	logic             advance;
	logic [7:0]       byte_s1;
	logic             res_valid;
	ftd_pkg::result_t res;
	ftd_pkg::result_t res_q;

	ftd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.blocked   (blocked),
		.advance   (advance),
		.byte_s1   (byte_s1)
	);

	ftd_parse #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ftd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (advance & res_valid),
		.res       (res),
		.blocked   (blocked),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign record_kind    = res_q.record_kind;
	assign format_version = res_q.format_version;
	assign header_flags   = res_q.header_flags;
	assign header_size    = res_q.header_size;
	assign tag_kind       = res_q.tag_kind;
	assign payload_size   = res_q.payload_size;
	assign time_stamp     = res_q.time_stamp;
	assign stream_number  = res_q.stream_number;
	assign tag_count      = res_q.tag_count;
	assign frame_number   = res_q.frame_number;

endmodule

// File: hw/rtl/ftd_checker.sv
module ftd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        record_kind,
	input logic [7:0]  tag_kind,
	input logic [23:0] payload_size,
	input logic [31:0] tag_count,
	input logic [31:0] frame_number
);

	// held record stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tag_count))
		else $error("held output record dropped or changed");

	// input only backs up behind a stalled record
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	a_frame_other: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == ftd_pkg::RECORD_TAG
		&& tag_kind != ftd_pkg::TAG_AUDIO && tag_kind != ftd_pkg::TAG_VIDEO
		|-> frame_number == 32'd0)
		else $error("frame number set for a non audio/video tag");

	a_file_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == ftd_pkg::RECORD_FILE
		|-> tag_count == 32'd0 && payload_size == 24'd0 && frame_number == 32'd0)
		else $error("tag fields set in a file header record");

endmodule

bind flv_tag_header_deframer ftd_checker u_ftd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.record_kind  (record_kind),
	.tag_kind     (tag_kind),
	.payload_size (payload_size),
	.tag_count    (tag_count),
	.frame_number (frame_number)
);
